### design/ajtd_pkg.sv
// Shared widths, constants, register indexes and types for the jerk threshold detector.
// No dependencies; every other design file refers to this package by scoped names.
package ajtd_pkg;

	// Field and state widths
	localparam int AXIS_W     = 16;
	localparam int DIFF_W     = AXIS_W + 1;
	localparam int SQ_W       = 32;
	localparam int SUM_W      = 34;
	localparam int TIME_W     = 32;
	localparam int THR_W      = 8;
	localparam int PERIOD_W   = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	// Register indexes on the write port
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 2'd2;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd50;

	// Threshold test: sum * 1e6 > (threshold * 2048 * interval)^2
	localparam int SCALE_W = 20;
	localparam logic [SCALE_W-1:0] JERK_SCALE = 20'd1000000;
	localparam int LSB_SHIFT = 11;                  // 2048 counts per g
	localparam int TERM_W    = 32;                  // a wider term always fails the test
	localparam int P_W       = THR_W + TIME_W;      // threshold * interval
	localparam int P_LIM_W   = TERM_W - LSB_SHIFT;  // product bits that keep the term narrow
	localparam int PSQ_W     = 2 * P_LIM_W;
	localparam int LHS_W     = SUM_W + SCALE_W;
	localparam int CMP_W     = PSQ_W + 2 * LSB_SHIFT;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MERGE,
		ST_MUL,
		ST_CMP
	} ajtd_state_t;

	// Decision taken for one transaction when it is accepted
	typedef struct packed {
		logic take;   // sample due and read succeeded
		logic fail;   // sample due but read failed
		logic hist;   // prior sample exists and time moved forward
	} ajtd_upd_t;

	// Sequencer steps seen by the compare pipeline
	typedef struct packed {
		logic merge;
		logic mul;
	} ajtd_step_t;

endpackage

### design/ajtd_lane.sv
// One axis lane: difference from the previous sample, squared and registered.
// Depends on ajtd_pkg.
module ajtd_lane (
	input  logic                              clk,
	input  logic                              load,
	input  logic signed [ajtd_pkg::AXIS_W-1:0] accel,
	input  logic signed [ajtd_pkg::AXIS_W-1:0] prev,
	output logic        [ajtd_pkg::SQ_W-1:0]   sq_s1
);

	logic signed [ajtd_pkg::DIFF_W-1:0]   diff;
	logic signed [2*ajtd_pkg::DIFF_W-1:0] prod;

	// Sign-extend both axes and take the difference
	assign diff = $signed({accel[ajtd_pkg::AXIS_W-1], accel})
	            - $signed({prev[ajtd_pkg::AXIS_W-1], prev});
	assign prod = diff * diff;

	// Square never exceeds 32 bits, so keep the low word
	always_ff @(posedge clk) begin
		if (load) begin
			sq_s1 <= prod[ajtd_pkg::SQ_W-1:0];
		end
	end

endmodule

### design/ajtd_merge.sv
// Merging stage: sums the three lane squares and holds the stored jerk sum and interval.
// Depends on ajtd_pkg.
module ajtd_merge (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           clear,
	input  logic                           merge,
	input  ajtd_pkg::ajtd_upd_t            upd,
	input  logic [ajtd_pkg::SQ_W-1:0]      sq_x,
	input  logic [ajtd_pkg::SQ_W-1:0]      sq_y,
	input  logic [ajtd_pkg::SQ_W-1:0]      sq_z,
	input  logic [ajtd_pkg::TIME_W-1:0]    elapsed,
	output logic [ajtd_pkg::SUM_W-1:0]     sum_q,
	output logic [ajtd_pkg::TIME_W-1:0]    interval_q,
	output logic [ajtd_pkg::TIME_W-1:0]    next_interval
);

	logic [ajtd_pkg::SUM_W-1:0] sum_new;

	// Combine the lanes
	assign sum_new = ajtd_pkg::SUM_W'(sq_x) + ajtd_pkg::SUM_W'(sq_y)
	               + ajtd_pkg::SUM_W'(sq_z);

	// Interval after this transaction, also fed ahead to the compare pipeline
	always_comb begin
		priority if (upd.take && upd.hist) begin
			next_interval = elapsed;
		end else if (upd.take) begin
			next_interval = '0;
		end else begin
			next_interval = interval_q;
		end
	end

	// Store on a successful sample; drop everything on an enable write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q      <= '0;
			interval_q <= '0;
		end else if (clear) begin
			sum_q      <= '0;
			interval_q <= '0;
		end else if (merge && upd.take) begin
			sum_q      <= upd.hist ? sum_new : '0;
			interval_q <= next_interval;
		end
	end

	a_zero_interval_zero_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(interval_q == '0) |-> (sum_q == '0))
		else $error("stored sum nonzero with zero interval");

endmodule

### design/ajtd_cmp.sv
// Threshold compare pipeline: scaled sum against the squared threshold term.
// Depends on ajtd_pkg.
module ajtd_cmp (
	input  logic                           clk,
	input  ajtd_pkg::ajtd_step_t           step,
	input  logic [ajtd_pkg::THR_W-1:0]     threshold,
	input  logic [ajtd_pkg::TIME_W-1:0]    next_interval,
	input  logic [ajtd_pkg::SUM_W-1:0]     sum,
	input  logic [ajtd_pkg::TIME_W-1:0]    interval,
	output logic                           over
);

	logic [ajtd_pkg::P_W-1:0]   p_full;
	logic [ajtd_pkg::P_W-1:0]   p_s1;
	logic [ajtd_pkg::LHS_W-1:0] lhs_s2;
	logic [ajtd_pkg::PSQ_W-1:0] psq_s2;
	logic                       small_s2;
	logic                       nz_s2;

	assign p_full = ajtd_pkg::P_W'(threshold) * ajtd_pkg::P_W'(next_interval);

	// Threshold times interval, formed while the merge stage stores
	always_ff @(posedge clk) begin
		if (step.merge) begin
			p_s1 <= p_full;
		end
	end

	// Scale the sum and square the term; a wide term can never be beaten
	always_ff @(posedge clk) begin
		if (step.mul) begin
			lhs_s2   <= ajtd_pkg::LHS_W'(sum) * ajtd_pkg::LHS_W'(ajtd_pkg::JERK_SCALE);
			psq_s2   <= ajtd_pkg::PSQ_W'(p_s1[ajtd_pkg::P_LIM_W-1:0])
			          * ajtd_pkg::PSQ_W'(p_s1[ajtd_pkg::P_LIM_W-1:0]);
			small_s2 <= (p_s1[ajtd_pkg::P_W-1:ajtd_pkg::P_LIM_W] == '0);
			nz_s2    <= (interval != '0);
		end
	end

	// Squared term carries the 2048 scale as a shift of 22
	assign over = nz_s2 && small_s2
	           && (ajtd_pkg::CMP_W'(lhs_s2) > {psq_s2, {(2*ajtd_pkg::LSB_SHIFT){1'b0}}});

endmodule

### design/accel_jerk_threshold_detector_top.sv
// Accelerometer jerk threshold detector, top level: handshakes, sequencer, sample state.
// Depends on ajtd_pkg, ajtd_lane, ajtd_merge and ajtd_cmp.
// Result path: an accepted transaction passes the merge, multiply and compare states, and the
// compare state loads the output register, waiting while an untaken result still holds it.
// A new transaction is taken only once the sequencer is back in the idle state.
// Input is taken again while a result still waits in the output register.
// Reset: asynchronous, active low; disabled, threshold zero, period 50 ms, state cleared.
module accel_jerk_threshold_detector_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [ajtd_pkg::CFG_IDX_W-1:0]       wr_index,
	input  logic [ajtd_pkg::CFG_DATA_W-1:0]      wr_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [ajtd_pkg::TIME_W-1:0]          time_ms,
	input  logic                                 read_ok,
	input  logic signed [ajtd_pkg::AXIS_W-1:0]   accel_x,
	input  logic signed [ajtd_pkg::AXIS_W-1:0]   accel_y,
	input  logic signed [ajtd_pkg::AXIS_W-1:0]   accel_z,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 sampled,
	output logic                                 sample_failed,
	output logic                                 over_threshold,
	output logic [ajtd_pkg::SUM_W-1:0]           jerk_sq_sum
);

	ajtd_pkg::ajtd_state_t state_q, state_d;
	ajtd_pkg::ajtd_step_t  step;
	ajtd_pkg::ajtd_upd_t   upd_d, upd_s1;

	logic                                enable_q;
	logic [ajtd_pkg::THR_W-1:0]          threshold_q;
	logic [ajtd_pkg::PERIOD_W-1:0]       period_q;
	logic                                clear;

	logic [ajtd_pkg::TIME_W-1:0]         last_time_q;
	logic signed [ajtd_pkg::AXIS_W-1:0]  prev_x_q, prev_y_q, prev_z_q;

	logic                                accept;
	logic [ajtd_pkg::TIME_W-1:0]         elapsed;
	logic [ajtd_pkg::TIME_W-1:0]         elapsed_s1;
	logic [ajtd_pkg::TIME_W-1:0]         time_s1;
	logic signed [ajtd_pkg::AXIS_W-1:0]  ax_s1, ay_s1, az_s1;
	logic [ajtd_pkg::SQ_W-1:0]           sq_x_s1, sq_y_s1, sq_z_s1;

	logic [ajtd_pkg::SUM_W-1:0]          sum_q;
	logic [ajtd_pkg::TIME_W-1:0]         interval_q;
	logic [ajtd_pkg::TIME_W-1:0]         next_interval;
	logic                                over;
	logic                                out_load;
	logic                                out_valid_q;

	assign accept = in_valid && in_ready;
	assign clear  = wr_en && (wr_index == ajtd_pkg::REG_ENABLE);

	// Configuration writes; indexes beyond the list are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			threshold_q <= '0;
			period_q    <= ajtd_pkg::PERIOD_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				ajtd_pkg::REG_ENABLE:    enable_q    <= wr_data[0];
				ajtd_pkg::REG_THRESHOLD: threshold_q <= wr_data[ajtd_pkg::THR_W-1:0];
				ajtd_pkg::REG_PERIOD:    period_q    <= wr_data[ajtd_pkg::PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	// Decide what this transaction does, against the state it finds
	assign elapsed = time_ms - last_time_q;
	always_comb begin
		logic due;
		due        = enable_q && (elapsed >= ajtd_pkg::TIME_W'(period_q));
		upd_d.take = due && read_ok;
		upd_d.fail = due && !read_ok;
		upd_d.hist = (last_time_q != '0) && (time_ms > last_time_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_s1 <= '0;
		end else if (accept) begin
			upd_s1 <= upd_d;
		end
	end

	// Capture the transaction payload
	always_ff @(posedge clk) begin
		if (accept) begin
			elapsed_s1 <= elapsed;
			time_s1    <= time_ms;
			ax_s1      <= accel_x;
			ay_s1      <= accel_y;
			az_s1      <= accel_z;
		end
	end

	// Axis lanes
	ajtd_lane u_lane_x (.clk(clk), .load(accept), .accel(accel_x), .prev(prev_x_q), .sq_s1(sq_x_s1));
	ajtd_lane u_lane_y (.clk(clk), .load(accept), .accel(accel_y), .prev(prev_y_q), .sq_s1(sq_y_s1));
	ajtd_lane u_lane_z (.clk(clk), .load(accept), .accel(accel_z), .prev(prev_z_q), .sq_s1(sq_z_s1));

	ajtd_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.clear        (clear),
		.merge        (step.merge),
		.upd          (upd_s1),
		.sq_x         (sq_x_s1),
		.sq_y         (sq_y_s1),
		.sq_z         (sq_z_s1),
		.elapsed      (elapsed_s1),
		.sum_q        (sum_q),
		.interval_q   (interval_q),
		.next_interval(next_interval)
	);

	ajtd_cmp u_cmp (
		.clk          (clk),
		.step         (step),
		.threshold    (threshold_q),
		.next_interval(next_interval),
		.sum          (sum_q),
		.interval     (interval_q),
		.over         (over)
	);

	// Sample time and previous axes; advance the time on any due sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_z_q    <= '0;
		end else if (clear) begin
			last_time_q <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_z_q    <= '0;
		end else if (step.merge) begin
			if (upd_s1.take || upd_s1.fail) begin
				last_time_q <= time_s1;
			end
			if (upd_s1.take) begin
				prev_x_q <= ax_s1;
				prev_y_q <= ay_s1;
				prev_z_q <= az_s1;
			end
		end
	end

	// Sequencer: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ajtd_pkg::ST_IDLE:  if (in_valid) state_d = ajtd_pkg::ST_MERGE;
			ajtd_pkg::ST_MERGE: state_d = ajtd_pkg::ST_MUL;
			ajtd_pkg::ST_MUL:   state_d = ajtd_pkg::ST_CMP;
			ajtd_pkg::ST_CMP:   if (!out_valid_q || out_ready) state_d = ajtd_pkg::ST_IDLE;
			default:            state_d = ajtd_pkg::ST_IDLE;
		endcase
	end

	// Sequencer: outputs
	always_comb begin
		in_ready   = (state_q == ajtd_pkg::ST_IDLE);
		step.merge = (state_q == ajtd_pkg::ST_MERGE);
		step.mul   = (state_q == ajtd_pkg::ST_MUL);
		out_load   = (state_q == ajtd_pkg::ST_CMP) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ajtd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Output register: hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sampled        <= upd_s1.take;
			sample_failed  <= upd_s1.fail;
			over_threshold <= enable_q && over;
			jerk_sq_sum    <= enable_q ? sum_q : '0;
		end
	end

	assign out_valid = out_valid_q;

	a_merge_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ajtd_pkg::ST_MERGE) |-> $past(in_valid && in_ready))
		else $error("merge step without an accepted transaction");

	a_result_from_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ajtd_pkg::ST_CMP))
		else $error("result offered outside the compare step");

	a_cmp_loads_free_output: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ajtd_pkg::ST_CMP) && !out_valid_q) |=> out_valid_q)
		else $error("compare step failed to load an empty output register");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(sampled && sample_failed))
		else $error("result both sampled and failed");

endmodule

### verif/accel_jerk_threshold_detector_top_test.sv
// Self-checking testbench for accel_jerk_threshold_detector_top: a directed pass, then random
// tick streams under several register settings, checked against an in-bench jerk predictor.
// Depends on ajtd_pkg and the design's top level; no files or arguments are read.
module accel_jerk_threshold_detector_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint unsigned MICRO_PER_UNIT = 1000000;
	localparam longint unsigned COUNTS_PER_G   = 2048;
	localparam int RESULT_LATENCY = 3;
	localparam int QUIET_LIMIT    = 4000;
	localparam int LONG_HOLD      = 500;

	typedef struct packed {
		logic [ajtd_pkg::TIME_W-1:0]        time_ms;
		logic                               read_ok;
		logic signed [ajtd_pkg::AXIS_W-1:0] accel_x;
		logic signed [ajtd_pkg::AXIS_W-1:0] accel_y;
		logic signed [ajtd_pkg::AXIS_W-1:0] accel_z;
	} tick_t;

	typedef struct packed {
		logic                       sampled;
		logic                       sample_failed;
		logic                       over_threshold;
		logic [ajtd_pkg::SUM_W-1:0] jerk_sq_sum;
	} jerk_result_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               wr_en = 1'b0;
	logic [ajtd_pkg::CFG_IDX_W-1:0]     wr_index = '0;
	logic [ajtd_pkg::CFG_DATA_W-1:0]    wr_data = '0;
	logic                               in_valid = 1'b0;
	logic                               in_ready;
	logic [ajtd_pkg::TIME_W-1:0]        time_ms = '0;
	logic                               read_ok = 1'b0;
	logic signed [ajtd_pkg::AXIS_W-1:0] accel_x = '0;
	logic signed [ajtd_pkg::AXIS_W-1:0] accel_y = '0;
	logic signed [ajtd_pkg::AXIS_W-1:0] accel_z = '0;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic                               sampled;
	logic                               sample_failed;
	logic                               over_threshold;
	logic [ajtd_pkg::SUM_W-1:0]         jerk_sq_sum;

	accel_jerk_threshold_detector_top dut (.*);

	initial forever #5 clk = ~clk;

	// Predictor copy of the registers and of the sample history
	logic                               cfg_enable = 1'b0;
	logic [ajtd_pkg::THR_W-1:0]         cfg_threshold = '0;
	logic [ajtd_pkg::PERIOD_W-1:0]      cfg_period = 16'd50;
	logic [ajtd_pkg::TIME_W-1:0]        st_last_time = '0;
	logic signed [ajtd_pkg::AXIS_W-1:0] st_prev_x = '0;
	logic signed [ajtd_pkg::AXIS_W-1:0] st_prev_y = '0;
	logic signed [ajtd_pkg::AXIS_W-1:0] st_prev_z = '0;
	logic [ajtd_pkg::SUM_W-1:0]         st_sum = '0;
	logic [ajtd_pkg::TIME_W-1:0]        st_interval = '0;

	tick_t        pending_ticks[$];
	jerk_result_t expected_results[$];
	int           mismatches = 0;
	logic         calm = 1'b0;

	// Stimulus generator history
	logic [ajtd_pkg::TIME_W-1:0]        gen_time = '0;
	logic signed [ajtd_pkg::AXIS_W-1:0] gen_x = '0;
	logic signed [ajtd_pkg::AXIS_W-1:0] gen_y = '0;
	logic signed [ajtd_pkg::AXIS_W-1:0] gen_z = '0;

	// Advance the jerk history by one tick and return the result it should produce
	function automatic jerk_result_t detector_step(input tick_t t);
		jerk_result_t r;
		logic [ajtd_pkg::TIME_W-1:0] elapsed;
		longint dx, dy, dz;
		logic [127:0] scaled_sum, limit_term;
		r = '0;
		if (cfg_enable) begin
			elapsed = t.time_ms - st_last_time;
			if (elapsed >= ajtd_pkg::TIME_W'(cfg_period)) begin
				if (t.read_ok) begin
					r.sampled = 1'b1;
					if (st_last_time != '0 && t.time_ms > st_last_time) begin
						dx = longint'($signed(t.accel_x)) - longint'(st_prev_x);
						dy = longint'($signed(t.accel_y)) - longint'(st_prev_y);
						dz = longint'($signed(t.accel_z)) - longint'(st_prev_z);
						st_sum = ajtd_pkg::SUM_W'(dx * dx + dy * dy + dz * dz);
						st_interval = t.time_ms - st_last_time;
					end else begin
						st_sum = '0;
						st_interval = '0;
					end
					st_prev_x = t.accel_x;
					st_prev_y = t.accel_y;
					st_prev_z = t.accel_z;
				end else begin
					r.sample_failed = 1'b1;
				end
				st_last_time = t.time_ms;
			end
			// compare at full width so no product can wrap
			if (st_interval != '0) begin
				scaled_sum = 128'(st_sum) * 128'(MICRO_PER_UNIT);
				limit_term = 128'(cfg_threshold) * 128'(COUNTS_PER_G) * 128'(st_interval);
				r.over_threshold = scaled_sum > limit_term * limit_term;
			end
			r.jerk_sq_sum = st_sum;
		end
		return r;
	endfunction

	// Always back to back when calm; else mostly back to back, often a short gap, now and then a long pause
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [ajtd_pkg::AXIS_W-1:0] pick_extreme();
		case ($urandom_range(0, 3))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return 16'hFFFF;
		endcase
	endfunction

	// Drive ticks from the pending queue, predicting each one as it is taken
	int unsigned send_gap = 0;
	always @(posedge clk or negedge arst_n) begin : tick_driver
		tick_t seen_tick;
		tick_t next_tick;
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				seen_tick = '{time_ms, read_ok, accel_x, accel_y, accel_z};
				expected_results.push_back(detector_step(seen_tick));
			end
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_ticks.size() != 0) begin
					next_tick = pending_ticks.pop_front();
					time_ms  <= next_tick.time_ms;
					read_ok  <= next_tick.read_ok;
					accel_x  <= next_tick.accel_x;
					accel_y  <= next_tick.accel_y;
					accel_z  <= next_tick.accel_z;
					in_valid <= 1'b1;
					send_gap <= pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Take results with random stalls; hold off for a long stretch twice to back up the input
	int unsigned rx_wait = 0;
	int          results_seen = 0;
	always @(posedge clk or negedge arst_n) begin : result_monitor
		jerk_result_t want;
		int unsigned hold;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait <= 0;
		end else if (out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result offered with no transaction outstanding");
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (sampled !== want.sampled) begin
					$error("sampled: expected %0d, got %0d", want.sampled, sampled);
					mismatches++;
				end
				if (sample_failed !== want.sample_failed) begin
					$error("sample_failed: expected %0d, got %0d",
						want.sample_failed, sample_failed);
					mismatches++;
				end
				if (over_threshold !== want.over_threshold) begin
					$error("over_threshold: expected %0d, got %0d",
						want.over_threshold, over_threshold);
					mismatches++;
				end
				if (jerk_sq_sum !== want.jerk_sq_sum) begin
					$error("jerk_sq_sum: expected %0d, got %0d", want.jerk_sq_sum, jerk_sq_sum);
					mismatches++;
				end
			end
			results_seen++;
			hold = (results_seen % 700 == 300) ? LONG_HOLD : pick_gap();
			rx_wait <= hold;
			out_ready <= (hold == 0);
		end else if (rx_wait != 0) begin
			rx_wait <= rx_wait - 1;
			out_ready <= (rx_wait == 1);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// End the run if nothing moves for too long
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || wr_en) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("accel_jerk_threshold_detector_top test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Wait until every queued tick is taken and every result checked, then let the pipe empty
	task automatic settle();
		while (pending_ticks.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (RESULT_LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ajtd_pkg::CFG_IDX_W-1:0] idx,
			input logic [ajtd_pkg::CFG_DATA_W-1:0] val);
		settle();
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			ajtd_pkg::REG_ENABLE: begin
				cfg_enable   = val[0];
				st_last_time = '0;
				st_prev_x    = '0;
				st_prev_y    = '0;
				st_prev_z    = '0;
				st_sum       = '0;
				st_interval  = '0;
			end
			ajtd_pkg::REG_THRESHOLD: cfg_threshold = val[ajtd_pkg::THR_W-1:0];
			ajtd_pkg::REG_PERIOD:    cfg_period = val[ajtd_pkg::PERIOD_W-1:0];
			default: ;
		endcase
	endtask

	task automatic push_tick(input logic [ajtd_pkg::TIME_W-1:0] t, input logic ok,
			input logic [ajtd_pkg::AXIS_W-1:0] x, input logic [ajtd_pkg::AXIS_W-1:0] y,
			input logic [ajtd_pkg::AXIS_W-1:0] z);
		pending_ticks.push_back('{t, ok, x, y, z});
	endtask

	// Mostly ticks spaced around the sample period, with jumps, wraps and repeats mixed in
	task automatic push_random_ticks(input int count);
		int unsigned pick;
		int unsigned span;
		logic ok;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				gen_time += cfg_period + $urandom_range(0, 3);
			else if (pick < 70)
				gen_time += $urandom_range(0, cfg_period);
			else if (pick < 78)
				gen_time -= $urandom_range(0, 100);
			else if (pick < 85)
				gen_time = $urandom;
			else if (pick < 90)
				gen_time = ($urandom_range(0, 1) != 0) ? '0 : 32'hFFFF_FFFF - $urandom_range(0, 200);
			else
				gen_time += cfg_period + $urandom_range(0, 5000);
			ok = ($urandom_range(0, 9) != 0);
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				gen_x = 16'($urandom);
				gen_y = 16'($urandom);
				gen_z = 16'($urandom);
			end else if (pick < 80) begin
				// small motion keeps the jerk near the threshold
				case ($urandom_range(0, 2))
					0: span = 4;
					1: span = 64;
					default: span = 1024;
				endcase
				gen_x += 16'($urandom_range(0, 2 * span) - span);
				gen_y += 16'($urandom_range(0, 2 * span) - span);
				gen_z += 16'($urandom_range(0, 2 * span) - span);
			end else if (pick < 90) begin
				gen_x = pick_extreme();
				gen_y = pick_extreme();
				gen_z = pick_extreme();
			end
			push_tick(gen_time, ok, gen_x, gen_y, gen_z);
		end
	endtask

	task automatic run_random_phase(input logic en, input logic [ajtd_pkg::THR_W-1:0] thr,
			input logic [ajtd_pkg::PERIOD_W-1:0] per, input logic quiet, input int count);
		write_reg(ajtd_pkg::REG_THRESHOLD, ajtd_pkg::CFG_DATA_W'(thr));
		write_reg(ajtd_pkg::REG_PERIOD, per);
		write_reg(ajtd_pkg::REG_ENABLE, ajtd_pkg::CFG_DATA_W'(en));
		calm <= quiet;
		push_random_ticks(count);
	endtask

	initial begin : stimulus
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// disabled out of reset: every field reads zero
		push_tick(32'd100, 1'b1, 16'h7FFF, 16'h8000, 16'h7FFF);
		write_reg(ajtd_pkg::REG_ENABLE, 16'd1);
		write_reg(ajtd_pkg::REG_THRESHOLD, 16'd1);

		// reset period of 50 ms
		push_tick(32'd10, 1'b1, 16'h0001, 16'h0002, 16'h0003);   // not yet due
		push_tick(32'd50, 1'b1, 16'h7FFF, 16'h8000, 16'h0000);   // first sample, no history
		push_tick(32'd100, 1'b1, 16'h8000, 16'h7FFF, 16'hFFFF);  // full swing on x and y
		push_tick(32'd149, 1'b1, 16'h0000, 16'h0000, 16'h0000);  // one short of due
		push_tick(32'd150, 1'b0, 16'h1234, 16'h5678, 16'h9ABC);  // failed read
		push_tick(32'd200, 1'b1, 16'h8000, 16'h7FFF, 16'hFFFF);  // no motion
		push_tick(32'd260, 1'b1, 16'h803C, 16'h7FFF, 16'hFFFF);  // just under threshold
		push_tick(32'd300, 1'b1, 16'h8104, 16'h7FFF, 16'hFFFF);  // just over threshold
		push_tick(32'hFFFF_FFF0, 1'b1, 16'h0000, 16'h0000, 16'h0000); // huge interval
		push_tick(32'd30, 1'b1, 16'h0100, 16'h0100, 16'h0100);   // time wrapped backwards

		// zero period: every tick is due
		write_reg(ajtd_pkg::REG_PERIOD, 16'd0);
		push_tick(32'd30, 1'b1, 16'h0100, 16'h0100, 16'h0100);   // same time again
		push_tick(32'd31, 1'b1, 16'h7FFF, 16'h8000, 16'h7FFF);
		push_tick(32'd31, 1'b0, 16'h0000, 16'h0000, 16'h0000);
		write_reg(ajtd_pkg::REG_THRESHOLD, 16'd255);
		push_tick(32'd32, 1'b1, 16'h8000, 16'h7FFF, 16'h8000);

		// dropping and restoring enable wipes the history
		write_reg(ajtd_pkg::REG_ENABLE, 16'd0);
		push_tick(32'd40, 1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		write_reg(ajtd_pkg::REG_ENABLE, 16'd1);
		push_tick(32'd0, 1'b1, 16'h0010, 16'h0020, 16'h0030);
		push_tick(32'd0, 1'b1, 16'h0040, 16'h0050, 16'h0060);
		push_tick(32'd5, 1'b1, 16'h7000, 16'h8000, 16'h0000);
		push_tick(32'd6, 1'b1, 16'h8000, 16'h7000, 16'hFFFF);

		// random streams across the register ranges
		run_random_phase(1'b1, 8'd0, 16'd0, 1'b0, 220);
		run_random_phase(1'b1, 8'd255, 16'd65535, 1'b0, 180);
		run_random_phase(1'b1, 8'd1, 16'd50, 1'b1, 220);
		run_random_phase(1'b1, 8'($urandom), 16'($urandom_range(1, 200)), 1'b0, 220);
		run_random_phase(1'b0, 8'd17, 16'd10, 1'b0, 60);
		run_random_phase(1'b1, 8'($urandom), 16'($urandom_range(0, 20)), 1'b1, 220);
		run_random_phase(1'b1, 8'd128, 16'd1000, 1'b0, 220);
		run_random_phase(1'b1, 8'($urandom), 16'($urandom), 1'b0, 180);

		settle();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("accel_jerk_threshold_detector_top test passed");
		else
			$display("accel_jerk_threshold_detector_top test failed");
		$finish;
	end

endmodule
